@@ sv/rvdec_pkg.sv @@
// Shared types and codes for the RV32I instruction decoder pipeline.
package rvdec_pkg;

  // Major opcodes, bits 6:0 of the instruction word
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_ALUI   = 7'h13;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_ALU    = 7'h33;
  localparam logic [6:0] OP_FENCE  = 7'h0f;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  localparam logic [4:0] RS2_ECALL  = 5'd0;
  localparam logic [4:0] RS2_EBREAK = 5'd1;

  typedef enum logic [5:0] {
    K_LUI    = 6'd0,  K_AUIPC = 6'd1,  K_JAL   = 6'd2,  K_JALR  = 6'd3,
    K_BEQ    = 6'd4,  K_BNE   = 6'd5,  K_BLT   = 6'd6,  K_BGE   = 6'd7,
    K_BLTU   = 6'd8,  K_BGEU  = 6'd9,
    K_LB     = 6'd10, K_LH    = 6'd11, K_LW    = 6'd12, K_LBU   = 6'd13,
    K_LHU    = 6'd14,
    K_ADDI   = 6'd15, K_SLTI  = 6'd16, K_SLTIU = 6'd17, K_XORI  = 6'd18,
    K_ORI    = 6'd19, K_ANDI  = 6'd20, K_SLLI  = 6'd21, K_SRLI  = 6'd22,
    K_SRAI   = 6'd23,
    K_SB     = 6'd24, K_SH    = 6'd25, K_SW    = 6'd26,
    K_ADD    = 6'd27, K_SUB   = 6'd28, K_SLL   = 6'd29, K_SLT   = 6'd30,
    K_SLTU   = 6'd31, K_XOR   = 6'd32, K_SRL   = 6'd33, K_SRA   = 6'd34,
    K_OR     = 6'd35, K_AND   = 6'd36,
    K_FENCE  = 6'd37, K_ECALL = 6'd38, K_EBREAK = 6'd39
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FUNCT = 2'd1,
    ST_BAD_OP    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FMT_NONE, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J, FMT_SHAMT
  } fmt_e;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic [5:0]         kind;
    logic [1:0]         status;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        target;
    logic [3:0]         fence_pred;
    logic [3:0]         fence_succ;
  } out_t;

  // Stage 1 -> stage 2
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    fmt_e        fmt;
    logic        tgt_en;
    logic        fence_en;
    logic [31:0] instruction;
    logic [31:0] address;
  } cls_t;

  // Stage 2 -> stage 3
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [31:0] imm;
    logic        tgt_en;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [3:0]  pred;
    logic [3:0]  succ;
    logic [31:0] address;
  } imm_t;

endpackage

@@ sv/rvdec_classify.sv @@
// Stage 1: sort the instruction word into a kind, a status and an immediate format.
module rvdec_classify import rvdec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  in_t  data_i,
  output logic valid_o,
  output cls_t data_o
);

  logic        valid_q;
  cls_t        data_q, data_d;
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rs2;
  kind_e       kind;
  status_e     status;
  fmt_e        fmt;
  logic        tgt_en, fence_en;

  assign op  = data_i.instruction[6:0];
  assign f3  = data_i.instruction[14:12];
  assign f7  = data_i.instruction[31:25];
  assign rs2 = data_i.instruction[24:20];

  always_comb begin
    kind     = K_LUI;
    status   = ST_OK;
    fmt      = FMT_NONE;
    tgt_en   = 1'b0;
    fence_en = 1'b0;
    unique case (op)
      OP_LUI: begin
        kind = K_LUI;   fmt = FMT_U;
      end
      OP_AUIPC: begin
        kind = K_AUIPC; fmt = FMT_U;
      end
      OP_JAL: begin
        kind = K_JAL;   fmt = FMT_J; tgt_en = 1'b1;
      end
      OP_JALR: begin
        kind = K_JALR;  fmt = FMT_I;
      end
      OP_BRANCH: begin
        fmt = FMT_B; tgt_en = 1'b1;
        unique case (f3)
          3'd0: kind = K_BEQ;
          3'd1: kind = K_BNE;
          3'd4: kind = K_BLT;
          3'd5: kind = K_BGE;
          3'd6: kind = K_BLTU;
          3'd7: kind = K_BGEU;
          default: status = ST_BAD_FUNCT;
        endcase
      end
      OP_LOAD: begin
        fmt = FMT_I;
        unique case (f3)
          3'd0: kind = K_LB;
          3'd1: kind = K_LH;
          3'd2: kind = K_LW;
          3'd4: kind = K_LBU;
          3'd5: kind = K_LHU;
          default: status = ST_BAD_FUNCT;
        endcase
      end
      OP_ALUI: begin
        fmt = FMT_I;
        unique case (f3)
          3'd0: kind = K_ADDI;
          3'd1: begin
            kind = K_SLLI; fmt = FMT_SHAMT;
          end
          3'd2: kind = K_SLTI;
          3'd3: kind = K_SLTIU;
          3'd4: kind = K_XORI;
          3'd5: begin
            fmt = FMT_SHAMT;
            if (f7 == F7_BASE)     kind = K_SRLI;
            else if (f7 == F7_ALT) kind = K_SRAI;
            else                   status = ST_BAD_FUNCT;
          end
          3'd6: kind = K_ORI;
          default: kind = K_ANDI;
        endcase
      end
      OP_STORE: begin
        fmt = FMT_S;
        unique case (f3)
          3'd0: kind = K_SB;
          3'd1: kind = K_SH;
          3'd2: kind = K_SW;
          default: status = ST_BAD_FUNCT;
        endcase
      end
      OP_ALU: begin
        unique case (f3)
          3'd0: begin
            if (f7 == F7_BASE)     kind = K_ADD;
            else if (f7 == F7_ALT) kind = K_SUB;
            else                   status = ST_BAD_FUNCT;
          end
          3'd1: kind = K_SLL;
          3'd2: kind = K_SLT;
          3'd3: kind = K_SLTU;
          3'd4: kind = K_XOR;
          3'd5: begin
            if (f7 == F7_BASE)     kind = K_SRL;
            else if (f7 == F7_ALT) kind = K_SRA;
            else                   status = ST_BAD_FUNCT;
          end
          3'd6: kind = K_OR;
          default: kind = K_AND;
        endcase
      end
      OP_FENCE: begin
        kind = K_FENCE; fence_en = 1'b1;
      end
      OP_SYSTEM: begin
        if (f7 == F7_BASE && rs2 == RS2_ECALL)       kind = K_ECALL;
        else if (f7 == F7_BASE && rs2 == RS2_EBREAK) kind = K_EBREAK;
        else                                         status = ST_BAD_FUNCT;
      end
      default: status = ST_BAD_OP;
    endcase

    // Drop everything but the register fields on a rejected word
    if (status != ST_OK) begin
      kind     = K_LUI;
      fmt      = FMT_NONE;
      tgt_en   = 1'b0;
      fence_en = 1'b0;
    end
  end

  always_comb begin
    data_d.kind        = kind;
    data_d.status      = status;
    data_d.fmt         = fmt;
    data_d.tgt_en      = tgt_en;
    data_d.fence_en    = fence_en;
    data_d.instruction = data_i.instruction;
    data_d.address     = data_i.address;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/rvdec_immgen.sv @@
// Stage 2: build the sign-extended immediate and split out the register and fence fields.
module rvdec_immgen import rvdec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  cls_t data_i,
  output logic valid_o,
  output imm_t data_o
);

  logic        valid_q;
  imm_t        data_q, data_d;
  logic [31:0] w;
  logic [31:0] imm;

  assign w = data_i.instruction;

  always_comb begin
    case (data_i.fmt)
      FMT_I:     imm = {{20{w[31]}}, w[31:20]};
      FMT_S:     imm = {{20{w[31]}}, w[31:25], w[11:7]};
      FMT_B:     imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      FMT_U:     imm = {w[31:12], 12'b0};
      FMT_J:     imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      FMT_SHAMT: imm = {27'b0, w[24:20]};
      default:   imm = 32'b0;
    endcase
  end

  always_comb begin
    data_d.kind    = data_i.kind;
    data_d.status  = data_i.status;
    data_d.imm     = imm;
    data_d.tgt_en  = data_i.tgt_en;
    data_d.rd      = w[11:7];
    data_d.rs1     = w[19:15];
    data_d.rs2     = w[24:20];
    data_d.pred    = data_i.fence_en ? w[27:24] : 4'b0;
    data_d.succ    = data_i.fence_en ? w[23:20] : 4'b0;
    data_d.address = data_i.address;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/rvdec_target.sv @@
// Stage 3: add the immediate to the address for branch and jump targets; output register.
module rvdec_target import rvdec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  imm_t data_i,
  output logic valid_o,
  output out_t data_o
);

  logic        valid_q;
  out_t        data_q, data_d;
  logic [31:0] sum;

  // Wraps modulo 2^32
  assign sum = data_i.address + data_i.imm;

  always_comb begin
    data_d.kind       = data_i.kind;
    data_d.status     = data_i.status;
    data_d.dest_reg   = data_i.rd;
    data_d.src1_reg   = data_i.rs1;
    data_d.src2_reg   = data_i.rs2;
    data_d.immediate  = data_i.imm;
    data_d.target     = data_i.tgt_en ? sum : 32'b0;
    data_d.fence_pred = data_i.pred;
    data_d.fence_succ = data_i.succ;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/rv32i_instruction_decoder.sv @@
// Top level of the three-stage RV32I instruction decoder pipeline.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   in_data_i  (instruction, address)
//   out      source     out_valid_o / out_stall_i out_data_o (kind .. fence_succ)
//
// An input word passes through the three stage registers (classify, immediate build,
// target add), each holding one word, to out_data_o. One instruction enters every
// cycle unless out_stall_i holds the full pipeline and raises in_stall_o.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stalled stage holds; an empty stage still advances, so bubbles are squeezed out
// and in_stall_o rises only when every stage is full and out_stall_i is high.
module rv32i_instruction_decoder import rvdec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic v1, v2, v3;
  logic en1, en2, en3;
  cls_t cls;
  imm_t immd;

  // Advance a stage when it is empty or when the stage after it advances
  assign en3 = !v3 || !out_stall_i;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign in_stall_o = !en1;

  rvdec_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (v1),
    .data_o  (cls)
  );

  rvdec_immgen u_immgen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .data_i  (cls),
    .valid_o (v2),
    .data_o  (immd)
  );

  rvdec_target u_target (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .data_i  (immd),
    .valid_o (v3),
    .data_o  (out_data_o)
  );

  assign out_valid_o = v3;

  // A rejected word carries no kind, immediate, target or fence bits
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.kind == K_LUI && out_data_o.immediate == 0 &&
      out_data_o.target == 0 && out_data_o.fence_pred == 0 && out_data_o.fence_succ == 0)
    else $error("rejected word carries decoded fields");

  // Only branches and jal produce a target
  a_target_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.target != 0 |->
      out_data_o.kind == K_JAL || out_data_o.kind == K_BEQ || out_data_o.kind == K_BNE ||
      out_data_o.kind == K_BLT || out_data_o.kind == K_BGE || out_data_o.kind == K_BLTU ||
      out_data_o.kind == K_BGEU)
    else $error("target set for a non-control-transfer kind");

  // Fence bits appear only on fence
  a_fence_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.fence_pred != 0 || out_data_o.fence_succ != 0) |->
      out_data_o.kind == K_FENCE && out_data_o.immediate == 0)
    else $error("fence bits on a non-fence word");

  // Backpressure reaches the input only with the whole pipe full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1 && v2 && v3 && out_stall_i)
    else $error("input stalled with an empty stage");

endmodule

@@ dv/rv32i_instruction_decoder_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the RV32I instruction decoder: directed and random words.
module rv32i_instruction_decoder_test;
  import rvdec_pkg::*;

  // Run length and guards. The limit sits far above the slowest correct run:
  // about 1400 words, each waiting out a sender gap and a long receiver stall.
  localparam int unsigned RANDOM_WORDS = 1350;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // funct3 slots that need a funct7 look
  localparam logic [2:0] F3_ADD_SUB = 3'd0;
  localparam logic [2:0] F3_SHL     = 3'd1;
  localparam logic [2:0] F3_SHR     = 3'd5;

  // Kind per funct3 slot, slot 7 first. Slots a mask rejects hold a filler.
  localparam logic [7:0][5:0] BRANCH_KIND =
    {K_BGEU, K_BLTU, K_BGE, K_BLT, K_LUI, K_LUI, K_BNE, K_BEQ};
  localparam logic [7:0][5:0] LOAD_KIND =
    {K_LUI, K_LUI, K_LHU, K_LBU, K_LUI, K_LW, K_LH, K_LB};
  localparam logic [7:0][5:0] STORE_KIND =
    {K_LUI, K_LUI, K_LUI, K_LUI, K_LUI, K_SW, K_SH, K_SB};
  localparam logic [7:0][5:0] ALUI_KIND =
    {K_ANDI, K_ORI, K_SRLI, K_XORI, K_SLTIU, K_SLTI, K_SLLI, K_ADDI};
  localparam logic [7:0][5:0] ALU_KIND =
    {K_AND, K_OR, K_SRL, K_XOR, K_SLTU, K_SLT, K_SLL, K_ADD};
  localparam logic [7:0] BRANCH_OK = 8'b1111_0011;
  localparam logic [7:0] LOAD_OK   = 8'b0011_0111;
  localparam logic [7:0] STORE_OK  = 8'b0000_0111;

  localparam logic [10:0][6:0] OPCODES = {OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH,
    OP_LOAD, OP_ALUI, OP_STORE, OP_ALU, OP_FENCE, OP_SYSTEM};

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_LONG} stall_mode_e;

  // One word in flight: what went in and the decode it must come back as
  typedef struct packed {
    in_t  item;
    out_t result;
  } decode_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  decode_entry_t pending_decodes[$];
  int unsigned   error_count  = 0;
  int unsigned   cycle_count  = 0;
  int unsigned   burst_left   = 0;
  int unsigned   stall_phase  = 0;
  stall_mode_e   stall_mode   = STALL_NONE;

  rv32i_instruction_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decode one word the way the block must: classify on opcode and funct fields,
  // build the immediate of the format, add the address for branches and jal.
  function automatic out_t decode_word(in_t item);
    logic [31:0] w;
    logic [6:0]  op;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [4:0]  rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    out_t        r;
    w     = item.instruction;
    op    = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    rs2   = w[24:20];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    r          = '0;
    r.status   = ST_OK;
    // register fields pass through raw, whatever the format
    r.dest_reg = w[11:7];
    r.src1_reg = w[19:15];
    r.src2_reg = rs2;
    case (op)
      OP_LUI: begin
        r.kind      = K_LUI;
        r.immediate = {w[31:12], 12'b0};
      end
      OP_AUIPC: begin
        r.kind      = K_AUIPC;
        r.immediate = {w[31:12], 12'b0};
      end
      OP_JAL: begin
        r.kind      = K_JAL;
        r.immediate = imm_j;
        r.target    = item.address + imm_j;
      end
      // jalr takes any funct3
      OP_JALR: begin
        r.kind      = K_JALR;
        r.immediate = imm_i;
      end
      OP_BRANCH: begin
        if (BRANCH_OK[f3]) begin
          r.kind      = BRANCH_KIND[f3];
          r.immediate = imm_b;
          r.target    = item.address + imm_b;
        end else begin
          r.status = ST_BAD_FUNCT;
        end
      end
      OP_LOAD: begin
        if (LOAD_OK[f3]) begin
          r.kind      = LOAD_KIND[f3];
          r.immediate = imm_i;
        end else begin
          r.status = ST_BAD_FUNCT;
        end
      end
      OP_ALUI: begin
        if (f3 == F3_SHL) begin
          // slli never looks at funct7
          r.kind      = K_SLLI;
          r.immediate = {27'b0, rs2};
        end else if (f3 == F3_SHR) begin
          if (f7 == F7_BASE) begin
            r.kind      = K_SRLI;
            r.immediate = {27'b0, rs2};
          end else if (f7 == F7_ALT) begin
            r.kind      = K_SRAI;
            r.immediate = {27'b0, rs2};
          end else begin
            r.status = ST_BAD_FUNCT;
          end
        end else begin
          r.kind      = ALUI_KIND[f3];
          r.immediate = imm_i;
        end
      end
      OP_STORE: begin
        if (STORE_OK[f3]) begin
          r.kind      = STORE_KIND[f3];
          r.immediate = imm_s;
        end else begin
          r.status = ST_BAD_FUNCT;
        end
      end
      OP_ALU: begin
        // only add/sub and srl/sra check funct7
        if (f3 == F3_ADD_SUB || f3 == F3_SHR) begin
          if (f7 == F7_BASE) r.kind = ALU_KIND[f3];
          else if (f7 == F7_ALT) r.kind = (f3 == F3_ADD_SUB) ? K_SUB : K_SRA;
          else r.status = ST_BAD_FUNCT;
        end else begin
          r.kind = ALU_KIND[f3];
        end
      end
      OP_FENCE: begin
        r.kind       = K_FENCE;
        r.fence_pred = w[27:24];
        r.fence_succ = w[23:20];
      end
      OP_SYSTEM: begin
        if (f7 == F7_BASE && rs2 == RS2_ECALL) r.kind = K_ECALL;
        else if (f7 == F7_BASE && rs2 == RS2_EBREAK) r.kind = K_EBREAK;
        else r.status = ST_BAD_FUNCT;
      end
      default: r.status = ST_BAD_OP;
    endcase
    // a rejected word keeps only its register fields
    if (r.status != ST_OK) begin
      r.kind       = '0;
      r.immediate  = '0;
      r.target     = '0;
      r.fence_pred = '0;
      r.fence_succ = '0;
    end
    return r;
  endfunction

  // Random word with the opcode and funct fields forced
  function automatic logic [31:0] make_word(logic [6:0] op, logic [2:0] f3, logic [6:0] f7);
    logic [31:0] w;
    w        = $urandom;
    w[6:0]   = op;
    w[14:12] = f3;
    w[31:25] = f7;
    return w;
  endfunction

  // Mostly well-formed words with random content; funct7 and rs2 are steered
  // where the decode depends on them. The rest is raw noise, mostly bad opcodes.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [6:0]  op;
    int unsigned pick;
    w = $urandom;
    if ($urandom_range(0, 99) < 12) return w;
    op     = OPCODES[$urandom_range(0, 10)];
    w[6:0] = op;
    case (op)
      OP_ALU, OP_ALUI: begin
        pick = $urandom_range(0, 4);
        if (pick < 2) w[31:25] = F7_BASE;
        else if (pick < 4) w[31:25] = F7_ALT;
      end
      OP_SYSTEM: begin
        if ($urandom_range(0, 3) != 0) w[31:25] = F7_BASE;
        pick = $urandom_range(0, 2);
        if (pick == 0) w[24:20] = RS2_ECALL;
        else if (pick == 1) w[24:20] = RS2_EBREAK;
      end
      default: ;
    endcase
    return w;
  endfunction

  // Send one word. Bursts of random length alternate with random gaps, and some
  // bursts start with no gap at all. Called and returning at a falling edge; valid
  // stays high on return so back-to-back words run without a bubble.
  task automatic issue_word(input logic [31:0] word, input logic [31:0] addr);
    in_t         item;
    int unsigned gap;
    item.instruction = word;
    item.address     = addr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        in_data_i  <= {$urandom, $urandom};
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    // hold the payload until the transfer happens
    do @(posedge clk_i); while (in_stall_o);
    pending_decodes.push_back('{item: item, result: decode_word(item)});
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got, input logic [31:0] word);
    if (got !== want) begin
      $error("%s mismatch for word %h: expected %h, actual %h", name, word, want, got);
      error_count++;
    end
  endtask

  // Receiver: switch stall pattern at random, from none to long stretches
  always @(negedge clk_i) begin
    if (stall_phase % 64 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
    stall_phase++;
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= 1'($urandom_range(0, 1));
      STALL_HEAVY:  out_stall_i <= (stall_phase % 4) != 0;
      default:      out_stall_i <= (stall_phase % 32) >= 18;
    endcase
  end

  // Check every output transfer against the oldest pending decode
  always @(posedge clk_i) begin
    decode_entry_t oldest;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_decodes.size() == 0) begin
        $error("result transfer with no pending decode: %h", out_data_o);
        error_count++;
      end else begin
        oldest = pending_decodes.pop_front();
        check_field("kind", 32'(oldest.result.kind), 32'(out_data_o.kind),
                    oldest.item.instruction);
        check_field("status", 32'(oldest.result.status), 32'(out_data_o.status),
                    oldest.item.instruction);
        check_field("dest_reg", 32'(oldest.result.dest_reg), 32'(out_data_o.dest_reg),
                    oldest.item.instruction);
        check_field("src1_reg", 32'(oldest.result.src1_reg), 32'(out_data_o.src1_reg),
                    oldest.item.instruction);
        check_field("src2_reg", 32'(oldest.result.src2_reg), 32'(out_data_o.src2_reg),
                    oldest.item.instruction);
        check_field("immediate", oldest.result.immediate, out_data_o.immediate,
                    oldest.item.instruction);
        check_field("target", oldest.result.target, out_data_o.target,
                    oldest.item.instruction);
        check_field("fence_pred", 32'(oldest.result.fence_pred),
                    32'(out_data_o.fence_pred), oldest.item.instruction);
        check_field("fence_succ", 32'(oldest.result.fence_succ),
                    32'(out_data_o.fence_succ), oldest.item.instruction);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rv32i_instruction_decoder_test: done, errors");
      $finish;
    end
  end

  // lui/auipc immediates, jal targets that wrap both ways, jalr with a nonzero funct3
  task automatic test_upper_and_jumps();
    issue_word(32'hFFFF_FFB7, 32'h0);
    issue_word(32'h0000_00B7, 32'hFFFF_FFFF);
    issue_word(make_word(OP_AUIPC, 3'($urandom), 7'($urandom)), $urandom);
    issue_word(32'h8000_006F, 32'h0);
    issue_word(32'hFFFF_F06F, 32'h0);
    issue_word(32'h7FFF_F0EF, 32'hFFFF_FFFF);
    issue_word(make_word(OP_JALR, 3'd6, 7'($urandom)), $urandom);
  endtask

  // Every funct3 slot, valid and not; targets near the top of memory wrap
  task automatic test_branches();
    for (int f3 = 0; f3 < 8; f3++)
      issue_word(make_word(OP_BRANCH, 3'(f3), 7'($urandom)), 32'hFFFF_FFF0);
    issue_word(32'hFE00_0FE3, 32'h0);
  endtask

  task automatic test_loads_stores();
    for (int f3 = 0; f3 < 8; f3++) issue_word(make_word(OP_LOAD, 3'(f3), 7'($urandom)), $urandom);
    for (int f3 = 0; f3 < 8; f3++) issue_word(make_word(OP_STORE, 3'(f3), 7'($urandom)), $urandom);
  endtask

  // All-ones funct7: slli still decodes, the right shifts reject it
  task automatic test_alu_imm();
    for (int f3 = 0; f3 < 8; f3++) issue_word(make_word(OP_ALUI, 3'(f3), 7'h7F), $urandom);
    issue_word(make_word(OP_ALUI, F3_SHR, F7_BASE), $urandom);
    issue_word(make_word(OP_ALUI, F3_SHR, F7_ALT), $urandom);
  endtask

  // Base funct7 for every slot, alternate for sub/sra, all-ones where it matters
  // and where it does not
  task automatic test_alu_reg();
    for (int f3 = 0; f3 < 8; f3++) issue_word(make_word(OP_ALU, 3'(f3), F7_BASE), $urandom);
    issue_word(make_word(OP_ALU, F3_ADD_SUB, F7_ALT), $urandom);
    issue_word(make_word(OP_ALU, F3_SHR, F7_ALT), $urandom);
    issue_word(make_word(OP_ALU, F3_ADD_SUB, 7'h7F), $urandom);
    issue_word(make_word(OP_ALU, 3'd3, 7'h7F), $urandom);
  endtask

  // Fence with any funct3; ecall/ebreak exact, ebreak loose; system with bad funct7
  task automatic test_fence_system();
    logic [31:0] w;
    issue_word(32'h0FF0_000F, $urandom);
    issue_word(make_word(OP_FENCE, 3'($urandom), 7'($urandom)), $urandom);
    issue_word(32'h0000_0073, $urandom);
    issue_word(32'h0010_0073, $urandom);
    w          = make_word(OP_SYSTEM, 3'($urandom), F7_BASE);
    w[24:20]   = RS2_EBREAK;
    issue_word(w, $urandom);
    issue_word(make_word(OP_SYSTEM, 3'd0, F7_ALT), $urandom);
  endtask

  // All-zero and all-one words carry no known opcode
  task automatic test_bad_opcode();
    issue_word(32'h0000_0000, 32'h0);
    issue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Random words; addresses lean toward both ends of memory to exercise wrap
  task automatic test_random();
    logic [31:0] addr;
    int unsigned pick;
    repeat (RANDOM_WORDS) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) addr = $urandom_range(0, 255);
      else if (pick == 1) addr = 32'hFFFF_FF00 | $urandom_range(0, 255);
      else addr = $urandom;
      issue_word(random_word(), addr);
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_upper_and_jumps();
    test_branches();
    test_loads_stores();
    test_alu_imm();
    test_alu_reg();
    test_fence_system();
    test_bad_opcode();
    test_random();

    // drop valid, drain the pipeline, then watch for strays
    in_valid_i <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("rv32i_instruction_decoder_test: done, clean");
    end else begin
      $display("rv32i_instruction_decoder_test: done, errors");
    end
    $finish;
  end

endmodule
